### hdl/scba_pkg.sv
package scba_pkg;

    localparam int UNIT_COUNT      = 1024;
    localparam int MIN_BLOCK_SHIFT = 12;
    localparam int UNIT_SHIFT      = 22;

    localparam int TOP_CLASS   = UNIT_SHIFT - MIN_BLOCK_SHIFT;
    localparam int CLASS_COUNT = TOP_CLASS + 1;
    localparam int WORD_W      = 64;
    localparam int BIT_W       = $clog2(WORD_W);
    localparam int UNIT_W      = $clog2(UNIT_COUNT);
    localparam int UWORD_W     = UNIT_W - BIT_W;
    localparam int BLK_W       = UNIT_SHIFT - MIN_BLOCK_SHIFT;
    localparam int BWORD_W     = BLK_W - BIT_W;
    localparam int CLS_W       = $clog2(CLASS_COUNT);
    localparam int CNT_W       = BLK_W + 1;
    localparam int CMAP_DEPTH  = CLASS_COUNT * (UNIT_COUNT / WORD_W);
    localparam int CMAP_AW     = CLS_W + UWORD_W;
    localparam int BMAP_AW     = UNIT_W + BWORD_W;
    localparam int ADDR_W      = 32;
    localparam int ORDER_W     = 5;

    typedef struct packed {
        logic [CLS_W-1:0] cls;
        logic [CNT_W-1:0] cap;
        logic [CNT_W-1:0] nfree;
    } desc_t;

    localparam desc_t TOP_DESC = '{cls: CLS_W'(TOP_CLASS), cap: CNT_W'(1), nfree: CNT_W'(1)};

endpackage

### hdl/scba_ffs.sv
module scba_ffs (
    input  logic [scba_pkg::WORD_W-1:0] vec,
    output logic                        found,
    output logic [scba_pkg::BIT_W-1:0]  idx
);
    import scba_pkg::*;

    logic [7:0] byte_any;
    logic [2:0] byte_sel;
    logic [2:0] bit_sel;
    logic [7:0] sel_byte;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            byte_any[i] = |vec[i*8 +: 8];
        end
    end

    // lowest nonzero byte, then lowest set bit within it
    always_comb
    begin
        byte_sel = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (byte_any[i])
            begin
                byte_sel = 3'(i);
            end
        end
    end

    assign sel_byte = vec[{byte_sel, 3'b000} +: 8];

    always_comb
    begin
        bit_sel = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (sel_byte[i])
            begin
                bit_sel = 3'(i);
            end
        end
    end

    assign found = |byte_any;
    assign idx   = {byte_sel, bit_sel};

endmodule

### hdl/size_class_bitmap_block_allocator.sv
// channel | direction | handshake             | payload
// request | in        | start & !busy accepts | action, size_order, free_address
// result  | out       | done strobe, 1 cycle  | status, block_address
//
// One item in flight at a time; busy stays high from accept until done pulses
// (an order out of range leaves busy low). An allocate scans a class bitmap
// word by word (up to 16 reads of the class map, a second pass over the 4 MB
// class if that fails) and then up to 16 block-map words of the chosen unit,
// all through one shared find-first unit. It ends in a hit in the class, a
// whole 4 MB unit, a conversion (two class passes plus a sweep of up to 16
// block words) or no space. An order out of range is answered in the
// cycle right after accept. After reset a clearing pass initializes the
// unit descriptors and class maps; busy is high during it. The receiver
// cannot stall results.
module size_class_bitmap_block_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          action,
    input  logic [scba_pkg::ORDER_W-1:0]  size_order,
    input  logic [scba_pkg::ADDR_W-1:0]   free_address,
    output logic                          done,
    output logic                          status,
    output logic [scba_pkg::ADDR_W-1:0]   block_address
);
    import scba_pkg::*;

    localparam logic [4:0] S_INIT     = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_CSCAN    = 5'd2;
    localparam logic [4:0] S_DWAIT    = 5'd3;
    localparam logic [4:0] S_BSCAN    = 5'd4;
    localparam logic [4:0] S_AWRITE   = 5'd5;
    localparam logic [4:0] S_TOPALLOC = 5'd6;
    localparam logic [4:0] S_CONV     = 5'd7;
    localparam logic [4:0] S_CONV2    = 5'd8;
    localparam logic [4:0] S_FWAIT1   = 5'd9;
    localparam logic [4:0] S_FCHK     = 5'd10;
    localparam logic [4:0] S_FWAIT2   = 5'd11;
    localparam logic [4:0] S_FBIT     = 5'd12;
    localparam logic [4:0] S_FCW      = 5'd13;
    localparam logic [4:0] S_FCLR     = 5'd14;
    localparam logic [4:0] S_FTW      = 5'd15;
    localparam logic [4:0] S_FSET     = 5'd16;

    localparam logic [CLS_W-1:0]   TOP_CLS   = CLS_W'(TOP_CLASS);
    localparam logic [UWORD_W-1:0] LAST_UWORD = UWORD_W'((UNIT_COUNT / WORD_W) - 1);

    // maps: class bitmaps, unit descriptors, per-unit block bitmaps
    logic [WORD_W-1:0] cmap [CMAP_DEPTH];
    desc_t             dmap [UNIT_COUNT];
    logic [WORD_W-1:0] bmap [UNIT_COUNT * (1 << BWORD_W)];

    logic [WORD_W-1:0]  cm_rdata_reg;
    desc_t              dm_rdata_reg;
    logic [WORD_W-1:0]  bm_rdata_reg;

    logic               cm_we;
    logic [CMAP_AW-1:0] cm_waddr;
    logic [WORD_W-1:0]  cm_wdata;
    logic               dm_we;
    logic [UNIT_W-1:0]  dm_waddr;
    desc_t              dm_wdata;
    logic               bm_we;
    logic [BMAP_AW-1:0] bm_waddr;
    logic [WORD_W-1:0]  bm_wdata;

    logic [4:0]           state_reg,  state_next;
    logic [UNIT_W-1:0]    init_reg,   init_next;
    logic [CLS_W-1:0]     cls_reg,    cls_next;
    logic [CLS_W-1:0]     scls_reg,   scls_next;
    logic                 phase_reg,  phase_next;
    logic [UWORD_W-1:0]   idx_reg,    idx_next;
    logic [UWORD_W-1:0]   cw_reg,     cw_next;
    logic                 ckv_reg,    ckv_next;
    logic [UNIT_W-1:0]    unit_reg,   unit_next;
    logic [UNIT_SHIFT-1:0] off_reg,   off_next;
    logic [BLK_W-1:0]     blk_reg,    blk_next;
    logic [WORD_W-1:0]    cword_reg,  cword_next;
    logic [WORD_W-1:0]    bword_reg,  bword_next;
    logic                 done_reg,   done_next;
    logic                 status_reg, status_next;
    logic [ADDR_W-1:0]    addr_reg,   addr_next;

    logic [WORD_W-1:0]  ffs_vec;
    logic               ffs_found;
    logic [BIT_W-1:0]   ffs_idx;

    logic [CNT_W-1:0]   cls_cap;
    logic [CNT_W-1:0]   nfree_inc;
    logic [UWORD_W-1:0] blk_last;
    logic [WORD_W-1:0]  cap_mask;
    logic [UNIT_SHIFT-1:0] blk_off;
    logic [UNIT_SHIFT-1:0] free_shift;
    logic [WORD_W-1:0]  unit_bit;

    scba_ffs u_ffs (
        .vec   (ffs_vec),
        .found (ffs_found),
        .idx   (ffs_idx)
    );

    // capacity of the requested class, and limits of the block scan
    assign cls_cap   = CNT_W'(1) << (TOP_CLS - cls_reg);
    assign blk_last  = (dm_rdata_reg.cap >= CNT_W'(WORD_W))
                     ? UWORD_W'((dm_rdata_reg.cap >> BIT_W) - CNT_W'(1)) : '0;
    assign cap_mask  = (dm_rdata_reg.cap >= CNT_W'(WORD_W))
                     ? '1 : ((WORD_W'(1) << dm_rdata_reg.cap[BIT_W-1:0]) - WORD_W'(1));
    assign nfree_inc = dm_rdata_reg.nfree + CNT_W'(1);
    assign blk_off   = UNIT_SHIFT'(blk_reg) << (5'(cls_reg) + 5'(MIN_BLOCK_SHIFT));
    assign free_shift = off_reg >> (5'(dm_rdata_reg.cls) + 5'(MIN_BLOCK_SHIFT));
    assign unit_bit  = WORD_W'(1) << unit_reg[BIT_W-1:0];

    // the one search unit: set bits of a class word, free bits of a block word
    assign ffs_vec = (state_reg == S_BSCAN) ? (~bm_rdata_reg & cap_mask) : cm_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cm_we)
        begin
            cmap[cm_waddr] <= cm_wdata;
        end
        cm_rdata_reg <= cmap[{scls_reg, idx_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (dm_we)
        begin
            dmap[dm_waddr] <= dm_wdata;
        end
        dm_rdata_reg <= dmap[unit_reg];
    end

    always_ff @(posedge clk)
    begin
        if (bm_we)
        begin
            bmap[bm_waddr] <= bm_wdata;
        end
        bm_rdata_reg <= bmap[{unit_reg, idx_reg}];
    end

    always_comb
    begin
        state_next  = state_reg;
        init_next   = init_reg;
        cls_next    = cls_reg;
        scls_next   = scls_reg;
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        cw_next     = cw_reg;
        ckv_next    = ckv_reg;
        unit_next   = unit_reg;
        off_next    = off_reg;
        blk_next    = blk_reg;
        cword_next  = cword_reg;
        bword_next  = bword_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        addr_next   = addr_reg;
        cm_we       = 1'b0;
        cm_waddr    = {scls_reg, unit_reg[UNIT_W-1:BIT_W]};
        cm_wdata    = '0;
        dm_we       = 1'b0;
        dm_waddr    = unit_reg;
        dm_wdata    = dm_rdata_reg;
        bm_we       = 1'b0;
        bm_waddr    = {unit_reg, idx_reg};
        bm_wdata    = '0;

        unique case (state_reg)
            S_INIT:
            begin
                // every unit is a free whole unit; only the top class row is set
                dm_we    = 1'b1;
                dm_waddr = init_reg;
                dm_wdata = TOP_DESC;
                if (32'(init_reg) < CMAP_DEPTH)
                begin
                    cm_we    = 1'b1;
                    cm_waddr = CMAP_AW'(init_reg);
                    cm_wdata = (init_reg[CMAP_AW-1:UWORD_W] == TOP_CLS) ? '1 : '0;
                end
                init_next = init_reg + UNIT_W'(1);
                if (init_reg == UNIT_W'(UNIT_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    if (action)
                    begin
                        unit_next  = free_address[ADDR_W-1 -: UNIT_W];
                        off_next   = free_address[UNIT_SHIFT-1:0];
                        state_next = S_FWAIT1;
                    end
                    else if (size_order < ORDER_W'(MIN_BLOCK_SHIFT) ||
                             size_order > ORDER_W'(UNIT_SHIFT))
                    begin
                        done_next   = 1'b1;
                        status_next = 1'b1;
                        addr_next   = '0;
                    end
                    else
                    begin
                        cls_next   = CLS_W'(size_order - ORDER_W'(MIN_BLOCK_SHIFT));
                        scls_next  = CLS_W'(size_order - ORDER_W'(MIN_BLOCK_SHIFT));
                        phase_next = 1'b0;
                        idx_next   = '0;
                        ckv_next   = 1'b0;
                        state_next = S_CSCAN;
                    end
                end
            end

            S_CSCAN:
            begin
                // issue one class word per cycle, check the word read last cycle
                idx_next = idx_reg + UWORD_W'(1);
                cw_next  = idx_reg;
                ckv_next = 1'b1;
                if (ckv_reg)
                begin
                    if (ffs_found)
                    begin
                        unit_next  = {cw_reg, ffs_idx};
                        cword_next = cm_rdata_reg;
                        if (phase_reg)
                        begin
                            idx_next   = '0;
                            state_next = S_CONV;
                        end
                        else if (cls_reg == TOP_CLS)
                        begin
                            state_next = S_TOPALLOC;
                        end
                        else
                        begin
                            state_next = S_DWAIT;
                        end
                    end
                    else if (cw_reg == LAST_UWORD)
                    begin
                        if (phase_reg || cls_reg == TOP_CLS)
                        begin
                            done_next   = 1'b1;
                            status_next = 1'b1;
                            addr_next   = '0;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            // class empty: look for a wholly free unit
                            phase_next = 1'b1;
                            scls_next  = TOP_CLS;
                            idx_next   = '0;
                            ckv_next   = 1'b0;
                        end
                    end
                end
            end

            S_DWAIT:
            begin
                idx_next   = '0;
                ckv_next   = 1'b0;
                state_next = S_BSCAN;
            end

            S_BSCAN:
            begin
                idx_next = idx_reg + UWORD_W'(1);
                cw_next  = idx_reg;
                ckv_next = 1'b1;
                if (ckv_reg)
                begin
                    if (ffs_found && dm_rdata_reg.nfree != '0)
                    begin
                        blk_next   = {cw_reg, ffs_idx};
                        bword_next = bm_rdata_reg;
                        state_next = S_AWRITE;
                    end
                    else if (ffs_found || cw_reg == blk_last)
                    begin
                        done_next   = 1'b1;
                        status_next = 1'b1;
                        addr_next   = '0;
                        state_next  = S_IDLE;
                    end
                end
            end

            S_AWRITE:
            begin
                bm_we    = 1'b1;
                bm_waddr = {unit_reg, blk_reg[BLK_W-1:BIT_W]};
                bm_wdata = bword_reg | (WORD_W'(1) << blk_reg[BIT_W-1:0]);
                dm_we    = 1'b1;
                dm_wdata = dm_rdata_reg;
                dm_wdata.nfree = dm_rdata_reg.nfree - CNT_W'(1);
                if (dm_rdata_reg.nfree == CNT_W'(1))
                begin
                    // unit now full: drop it from the class map
                    cm_we    = 1'b1;
                    cm_waddr = {cls_reg, unit_reg[UNIT_W-1:BIT_W]};
                    cm_wdata = cword_reg & ~unit_bit;
                end
                done_next   = 1'b1;
                status_next = 1'b0;
                addr_next   = {unit_reg, blk_off};
                state_next  = S_IDLE;
            end

            S_TOPALLOC:
            begin
                bm_we    = 1'b1;
                bm_waddr = {unit_reg, {BWORD_W{1'b0}}};
                bm_wdata = WORD_W'(1);
                dm_we    = 1'b1;
                dm_wdata = '{cls: TOP_CLS, cap: CNT_W'(1), nfree: '0};
                cm_we    = 1'b1;
                cm_waddr = {TOP_CLS, unit_reg[UNIT_W-1:BIT_W]};
                cm_wdata = cword_reg & ~unit_bit;
                done_next   = 1'b1;
                status_next = 1'b0;
                addr_next   = {unit_reg, {UNIT_SHIFT{1'b0}}};
                state_next  = S_IDLE;
            end

            S_CONV:
            begin
                // sweep the unit's block words: block 0 taken, rest free
                bm_we    = 1'b1;
                bm_waddr = {unit_reg, idx_reg};
                bm_wdata = (idx_reg == '0) ? WORD_W'(1) : '0;
                if (idx_reg == '0)
                begin
                    dm_we    = 1'b1;
                    dm_wdata = '{cls: cls_reg, cap: cls_cap, nfree: cls_cap - CNT_W'(1)};
                    cm_we    = 1'b1;
                    cm_waddr = {TOP_CLS, unit_reg[UNIT_W-1:BIT_W]};
                    cm_wdata = cword_reg & ~unit_bit;
                end
                idx_next = idx_reg + UWORD_W'(1);
                if (cls_cap <= CNT_W'(WORD_W) ||
                    idx_reg == UWORD_W'((cls_cap >> BIT_W) - CNT_W'(1)))
                begin
                    state_next = S_CONV2;
                end
            end

            S_CONV2:
            begin
                // the class row was found all zero, so write the bit alone
                cm_we    = 1'b1;
                cm_waddr = {cls_reg, unit_reg[UNIT_W-1:BIT_W]};
                cm_wdata = unit_bit;
                done_next   = 1'b1;
                status_next = 1'b0;
                addr_next   = {unit_reg, {UNIT_SHIFT{1'b0}}};
                state_next  = S_IDLE;
            end

            S_FWAIT1:
            begin
                state_next = S_FCHK;
            end

            S_FCHK:
            begin
                if (dm_rdata_reg.cls > TOP_CLS ||
                    (dm_rdata_reg.cls == TOP_CLS && dm_rdata_reg.nfree != '0))
                begin
                    // wholly free unit: nothing to clear
                    done_next   = 1'b1;
                    status_next = 1'b0;
                    addr_next   = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    // a wholly allocated unit lands on block 0 of word 0
                    blk_next   = BLK_W'(free_shift);
                    idx_next   = free_shift[BLK_W-1:BIT_W];
                    state_next = S_FWAIT2;
                end
            end

            S_FWAIT2:
            begin
                state_next = S_FBIT;
            end

            S_FBIT:
            begin
                if (!bm_rdata_reg[blk_reg[BIT_W-1:0]])
                begin
                    done_next   = 1'b1;
                    status_next = 1'b0;
                    addr_next   = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    bm_we    = 1'b1;
                    bm_waddr = {unit_reg, blk_reg[BLK_W-1:BIT_W]};
                    bm_wdata = bm_rdata_reg & ~(WORD_W'(1) << blk_reg[BIT_W-1:0]);
                    dm_we    = 1'b1;
                    if (nfree_inc != dm_rdata_reg.cap)
                    begin
                        dm_wdata       = dm_rdata_reg;
                        dm_wdata.nfree = nfree_inc;
                        done_next   = 1'b1;
                        status_next = 1'b0;
                        addr_next   = '0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        // unit empty again: hand it back to the top class
                        dm_wdata   = TOP_DESC;
                        scls_next  = dm_rdata_reg.cls;
                        idx_next   = unit_reg[UNIT_W-1:BIT_W];
                        state_next = S_FCW;
                    end
                end
            end

            S_FCW:
            begin
                state_next = S_FCLR;
            end

            S_FCLR:
            begin
                cm_we      = 1'b1;
                cm_waddr   = {scls_reg, unit_reg[UNIT_W-1:BIT_W]};
                cm_wdata   = cm_rdata_reg & ~unit_bit;
                scls_next  = TOP_CLS;
                state_next = S_FTW;
            end

            S_FTW:
            begin
                state_next = S_FSET;
            end

            S_FSET:
            begin
                cm_we    = 1'b1;
                cm_waddr = {TOP_CLS, unit_reg[UNIT_W-1:BIT_W]};
                cm_wdata = cm_rdata_reg | unit_bit;
                done_next   = 1'b1;
                status_next = 1'b0;
                addr_next   = '0;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            init_reg   <= '0;
            done_reg   <= 1'b0;
            ckv_reg    <= 1'b0;
            phase_reg  <= 1'b0;
            cls_reg    <= '0;
            scls_reg   <= '0;
            idx_reg    <= '0;
            cw_reg     <= '0;
            unit_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            init_reg   <= init_next;
            done_reg   <= done_next;
            ckv_reg    <= ckv_next;
            phase_reg  <= phase_next;
            cls_reg    <= cls_next;
            scls_reg   <= scls_next;
            idx_reg    <= idx_next;
            cw_reg     <= cw_next;
            unit_reg   <= unit_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        off_reg    <= off_next;
        blk_reg    <= blk_next;
        cword_reg  <= cword_next;
        bword_reg  <= bword_next;
        status_reg <= status_next;
        addr_reg   <= addr_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign block_address = addr_reg;

endmodule

### dv/tb_size_class_bitmap_block_allocator.sv
module tb_size_class_bitmap_block_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import scba_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int BLOCKS_MAX   = 1 << BLK_W;

    // Operation codes carried by the action port.
    typedef enum logic {OP_ALLOC = 1'b0, OP_FREE = 1'b1} op_e;

    typedef struct {
        op_e              op;
        logic [ORDER_W-1:0] order;
        logic [ADDR_W-1:0]  addr;
        int               gap;
    } request_t;

    typedef struct {
        logic             status;
        logic [ADDR_W-1:0] addr;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic action = 1'b0;
    logic [ORDER_W-1:0] size_order = '0;
    logic [ADDR_W-1:0]  free_address = '0;
    logic busy, done, status;
    logic [ADDR_W-1:0] block_address;

    size_class_bitmap_block_allocator DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .action(action), .size_order(size_order), .free_address(free_address),
        .done(done), .status(status), .block_address(block_address)
    );

    always #5 clk = ~clk;

    // Shadow allocator state: per-unit class, capacity, free count and
    // block-in-use bits. unit_flag marks a unit as set in the bitmap of its
    // own class; a full unit drops out and only comes back once wholly free.
    int unsigned  unit_cls   [UNIT_COUNT];
    int unsigned  unit_cap   [UNIT_COUNT];
    int unsigned  unit_nfree [UNIT_COUNT];
    bit           unit_flag  [UNIT_COUNT];
    bit           block_used [UNIT_COUNT][BLOCKS_MAX];

    request_t pending_items[$];
    answer_t  expected_answers[$];
    logic [ADDR_W-1:0] live_blocks[$];

    int mismatches = 0;
    int cycles = 0;
    int n_alloc = 0, n_free = 0, n_nospace = 0, n_answers = 0;
    bit stim_done = 1'b0;

    function automatic answer_t predict_allocate(logic [ORDER_W-1:0] order);
        answer_t a;
        int unsigned cls, u, b, found;
        a.status = 1'b1;
        a.addr   = '0;
        if (order < MIN_BLOCK_SHIFT || order > UNIT_SHIFT)
            return a;
        cls = order - MIN_BLOCK_SHIFT;
        found = UNIT_COUNT;
        // Lowest unit flagged in the class bitmap; a wholly free unit is
        // flagged in the top class.
        for (u = 0; u < UNIT_COUNT; u++)
            if (unit_cls[u] == cls && unit_flag[u])
            begin
                found = u;
                break;
            end
        if (found < UNIT_COUNT)
        begin
            u = found;
            for (b = 0; b < unit_cap[u]; b++)
                if (!block_used[u][b])
                    break;
            if (b >= unit_cap[u] || unit_nfree[u] == 0)
                return a;
            unit_nfree[u]--;
            if (unit_nfree[u] == 0)
                unit_flag[u] = 1'b0;
        end
        else
        begin
            for (u = 0; u < UNIT_COUNT; u++)
                if (unit_cls[u] == TOP_CLASS && unit_flag[u])
                    break;
            if (u >= UNIT_COUNT)
                return a;
            unit_cls[u]   = cls;
            unit_cap[u]   = 1 << (UNIT_SHIFT - order);
            unit_nfree[u] = unit_cap[u] - 1;
            unit_flag[u]  = 1'b1;
            b = 0;
        end
        block_used[u][b] = 1'b1;
        a.status = 1'b0;
        a.addr   = ADDR_W'((longint'(u) << UNIT_SHIFT) + (longint'(b) << order));
        return a;
    endfunction

    function automatic void predict_free(logic [ADDR_W-1:0] addr);
        int unsigned u, b;
        u = addr >> UNIT_SHIFT;
        if (u >= UNIT_COUNT)
            return;
        b = (addr & ((1 << UNIT_SHIFT) - 1)) >> (unit_cls[u] + MIN_BLOCK_SHIFT);
        if (b >= unit_cap[u] || !block_used[u][b])
            return;
        block_used[u][b] = 1'b0;
        unit_nfree[u]++;
        // Return an emptied unit to the top class.
        if (unit_nfree[u] == unit_cap[u])
        begin
            unit_cls[u]   = TOP_CLASS;
            unit_cap[u]   = 1;
            unit_nfree[u] = 1;
            unit_flag[u]  = 1'b1;
        end
    endfunction

    function automatic void queue_item(op_e op, int order, logic [ADDR_W-1:0] addr);
        request_t r;
        r.op    = op;
        r.order = ORDER_W'(order);
        r.addr  = addr;
        // Keep a third of items back to back, the rest with random gaps.
        r.gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
        pending_items.push_back(r);
    endfunction

    // Driver: present the next item at a falling edge after its gap, and hold
    // start until an accepting rising edge (start & !busy).
    int  gap_left = 0;
    bit  gap_armed = 1'b0;
    bit  accepted_last = 1'b0;
    always @(negedge clk)
    begin
        if (rst_n && !(start && !accepted_last))
        begin
            if (pending_items.size() == 0)
                start <= 1'b0;
            else
            begin
                if (!gap_armed)
                begin
                    gap_left  = pending_items[0].gap;
                    gap_armed = 1'b1;
                end
                if (gap_left == 0)
                    launch_item();
                else
                begin
                    gap_left--;
                    start <= 1'b0;
                end
            end
        end
    end

    task automatic launch_item();
        request_t r;
        answer_t  a;
        r = pending_items.pop_front();
        gap_armed = 1'b0;
        start        <= 1'b1;
        action       <= r.op;
        size_order   <= r.order;
        free_address <= r.addr;
        // Predict now: items are accepted in order, one at a time.
        if (r.op == OP_ALLOC)
        begin
            a = predict_allocate(r.order);
            n_alloc++;
            if (a.status)
                n_nospace++;
            else
                live_blocks.push_back(a.addr);
        end
        else
        begin
            predict_free(r.addr);
            a.status = 1'b0;
            a.addr   = '0;
            n_free++;
        end
        expected_answers.push_back(a);
    endtask

    // Sample handshakes at the rising edge.
    always @(posedge clk)
    begin
        answer_t e;
        cycles++;
        accepted_last <= start && !busy && rst_n;
        if (rst_n && done)
        begin
            n_answers++;
            if (expected_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0b addr %08h", status, block_address);
            end
            else
            begin
                e = expected_answers.pop_front();
                if (status !== e.status || block_address !== e.addr)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp status %0b addr %08h, got %0b %08h",
                                 e.status, e.addr, status, block_address);
                end
            end
        end
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [ADDR_W-1:0] pick_live();
        int i;
        logic [ADDR_W-1:0] a;
        i = $urandom_range(0, live_blocks.size() - 1);
        a = live_blocks[i];
        live_blocks.delete(i);
        return a;
    endfunction

    initial
    begin
        int i, k, o;
        logic [ADDR_W-1:0] a;
        for (i = 0; i < UNIT_COUNT; i++)
        begin
            unit_cls[i] = TOP_CLASS;
            unit_cap[i] = 1;
            unit_nfree[i] = 1;
            unit_flag[i] = 1'b1;
            for (k = 0; k < BLOCKS_MAX; k++)
                block_used[i][k] = 1'b0;
        end

        // Directed: every legal order, orders out of range, frees of extremes,
        // a double free, an unaligned free and a free of the last byte of the space.
        for (o = MIN_BLOCK_SHIFT; o <= UNIT_SHIFT; o++)
            queue_item(OP_ALLOC, o, $urandom);
        queue_item(OP_ALLOC, 0, 32'h0);
        queue_item(OP_ALLOC, MIN_BLOCK_SHIFT - 1, 32'hFFFF_FFFF);
        queue_item(OP_ALLOC, UNIT_SHIFT + 1, 32'h0);
        queue_item(OP_ALLOC, 31, 32'h0);
        queue_item(OP_FREE, 31, 32'h0000_0000);           // first 4 KB block
        queue_item(OP_FREE, 0, 32'h0000_0000);            // double free
        queue_item(OP_FREE, 0, 32'h0040_1FFF);            // unaligned, unit 1
        queue_item(OP_FREE, 0, 32'hFFFF_FFFF);            // last byte, unit 1023
        queue_item(OP_FREE, 0, 32'h3FF0_0000);            // wholly free unit
        queue_item(OP_FREE, 0, 32'h00C0_0000);            // unit 3 block

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Random: mostly allocate/free of live blocks with random low offsets.
        for (i = 0; i < 430; i++)
        begin
            while (pending_items.size() > 4)
                @(posedge clk);
            k = $urandom_range(0, 9);
            if (k < 5)
            begin
                // Bias toward small orders; sometimes any 5-bit order.
                o = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                : $urandom_range(12, 17);
                if ($urandom_range(0, 7) == 0)
                    o = $urandom_range(18, 22);
                queue_item(OP_ALLOC, o, $urandom);
            end
            else if (k < 9 && live_blocks.size() > 0)
            begin
                a = pick_live() | ADDR_W'($urandom_range(0, 4095));
                queue_item(OP_FREE, $urandom_range(0, 31), a);
            end
            else
                queue_item(OP_FREE, $urandom_range(0, 31), $urandom);
        end

        while (pending_items.size() > 0 || expected_answers.size() > 0 || start)
            @(posedge clk);
        repeat (60) @(posedge clk);

        $display("covered %0d allocates (%0d without space) and %0d frees, %0d results",
                 n_alloc, n_nospace, n_free, n_answers);
        if (mismatches == 0 && expected_answers.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
